FILE: rtl/core/bbrs_pkg.sv
package bbrs_pkg;

    // geometry limits
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_H_RADIUS = 15;
    localparam int MAX_V_RADIUS = 15;
    localparam int MAX_HEIGHT   = 4096;

    // field and register widths
    localparam int PIX_W          = 8;
    localparam int PIX_MAX        = (1 << PIX_W) - 1;
    localparam int COL_W          = $clog2(MAX_WIDTH);
    localparam int ROW_W          = $clog2(MAX_HEIGHT);
    localparam int RADIUS_W       = 4;
    localparam int LINE_WIDTH_W   = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 13;

    // window geometry
    localparam int H_DEPTH = 2 * MAX_H_RADIUS + 1;
    localparam int V_DEPTH = 2 * MAX_V_RADIUS + 1;
    localparam int HR_W    = $clog2(MAX_H_RADIUS + 1);
    localparam int VR_W    = $clog2(MAX_V_RADIUS + 1);
    localparam int HLEN_W  = $clog2(H_DEPTH + 1);
    localparam int VLEN_W  = $clog2(V_DEPTH + 1);
    localparam int HSLOT_W = $clog2(H_DEPTH);
    localparam int VSLOT_W = $clog2(V_DEPTH);

    // sums
    localparam int RSUM_W = $clog2(PIX_MAX * H_DEPTH + 1);
    localparam int CSUM_W = $clog2(PIX_MAX * H_DEPTH * V_DEPTH + 1);
    localparam int AREA_W = $clog2(H_DEPTH * V_DEPTH + 1);

    // reciprocal scaling
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] RECIP_NUM = 24'hFFFFFF;
    localparam int PROD_W      = CSUM_W + RECIP_W;

    // row sum store
    localparam int STORE_DEPTH = V_DEPTH * MAX_WIDTH;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // output queue
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OCC_W     = $clog2(OUT_DEPTH + 1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_H_RADIUS     = 3'd0,
        CFG_V_RADIUS     = 3'd1,
        CFG_LINE_WIDTH   = 3'd2,
        CFG_FRAME_HEIGHT = 3'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             last;
    } result_t;

    typedef struct packed {
        logic               busy;
        logic [RECIP_W-1:0] quotient;
    } div_status_t;

endpackage

FILE: rtl/core/bbrs_ram.sv
module bbrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/bbrs_recip_div.sv
module bbrs_recip_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bbrs_pkg::AREA_W-1:0] divisor,
    output bbrs_pkg::div_status_t      status
);

    localparam int CNT_W = $clog2(bbrs_pkg::RECIP_W);

    logic                          busy_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [bbrs_pkg::AREA_W-1:0]   rem_reg;
    logic [bbrs_pkg::AREA_W-1:0]   div_reg;
    logic [bbrs_pkg::RECIP_W-1:0]  quot_reg;

    logic [bbrs_pkg::AREA_W:0]     trial;
    logic                          ge;
    logic [bbrs_pkg::AREA_W-1:0]   rem_next;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial    = {rem_reg, quot_reg[bbrs_pkg::RECIP_W-1]};
        ge       = trial >= {1'b0, div_reg};
        rem_next = ge ? bbrs_pkg::AREA_W'(trial - {1'b0, div_reg})
                      : bbrs_pkg::AREA_W'(trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(bbrs_pkg::RECIP_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            div_reg  <= divisor;
            quot_reg <= bbrs_pkg::RECIP_NUM;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[bbrs_pkg::RECIP_W-2:0], ge};
        end
    end

    assign status.busy     = busy_reg;
    assign status.quotient = quot_reg;

endmodule

FILE: rtl/core/bbrs_out_queue.sv
module bbrs_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bbrs_pkg::result_t push_data,
    input  logic              pop,
    output logic              head_valid,
    output bbrs_pkg::result_t head_data
);

    bbrs_pkg::result_t                entry_reg [bbrs_pkg::OUT_DEPTH];
    logic [bbrs_pkg::OUT_PTR_W-1:0]   wr_ptr_reg;
    logic [bbrs_pkg::OUT_PTR_W-1:0]   rd_ptr_reg;
    logic [bbrs_pkg::OCC_W-1:0]       count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + bbrs_pkg::OUT_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + bbrs_pkg::OUT_PTR_W'(1);
            end
            count_reg <= count_reg + bbrs_pkg::OCC_W'(push) - bbrs_pkg::OCC_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = count_reg != '0;
    assign head_data  = entry_reg[rd_ptr_reg];

endmodule

FILE: rtl/core/box_blur_running_sum.sv
// box blur over a raster stream of 8-bit grey pixels, one pixel accepted per
// clock when the output side keeps up. a running horizontal sum feeds a row
// sum store (one 13-bit entry per column for each of the last 2*v_radius+1
// rows) and a column sum memory; both are synchronous rams updated
// read-modify-write, with a bypass when back-to-back pixels touch the same
// entry. a pixel whose window is complete gives its centered average
// (sum * floor(0xffffff/area)) >> 24; it passes the s1, s2 and s3 registers
// and the output queue before out_valid rises. border pixels give nothing.
// results wait in an 8-entry queue, and in_ready drops when the queue plus
// the three pipeline stages hold 8 pending results. after reset and after
// every write to a defined register the reciprocal is rebuilt by a
// bit-serial divider, and in_ready stays low until it is done. every such
// write also restarts the frame at row 0, column 0. no clearing pass is
// needed: column sums restart from zero on row 0 of each frame
module box_blur_running_sum (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bbrs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bbrs_pkg::CFG_DATA_W-1:0]  cfg_data,
    // pixel input
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [bbrs_pkg::PIX_W-1:0]       pixel_in,
    // blurred output
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bbrs_pkg::PIX_W-1:0]       pixel_out,
    output logic [bbrs_pkg::COL_W-1:0]       out_column,
    output logic [bbrs_pkg::ROW_W-1:0]       out_row,
    output logic                            frame_last
);

    // configuration registers
    logic [bbrs_pkg::RADIUS_W-1:0]       h_radius_reg;
    logic [bbrs_pkg::RADIUS_W-1:0]       v_radius_reg;
    logic [bbrs_pkg::LINE_WIDTH_W-1:0]   line_width_reg;
    logic [bbrs_pkg::FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic                                start_reg;

    // stream position and horizontal window
    logic [bbrs_pkg::COL_W-1:0]   col_reg;
    logic [bbrs_pkg::ROW_W-1:0]   row_reg;
    logic [bbrs_pkg::HSLOT_W-1:0] hslot_reg;
    logic [bbrs_pkg::VSLOT_W-1:0] vslot_reg;
    logic [bbrs_pkg::RSUM_W-1:0]  row_sum_reg;
    logic [bbrs_pkg::PIX_W-1:0]   window_reg [bbrs_pkg::H_DEPTH];

    // stage 1: memory read data returns
    logic                          s1_valid_reg;
    logic [bbrs_pkg::COL_W-1:0]    s1_col_reg;
    logic [bbrs_pkg::STORE_AW-1:0] s1_addr_reg;
    logic [bbrs_pkg::RSUM_W-1:0]   s1_rsum_reg;
    logic                          s1_row_zero_reg;
    logic                          s1_sub_reg;
    logic                          s1_emit_reg;
    logic [bbrs_pkg::ROW_W-1:0]    s1_row_reg;
    logic                          s1_last_reg;
    logic                          byp_col_hit_reg;
    logic [bbrs_pkg::CSUM_W-1:0]   byp_col_data_reg;
    logic                          byp_store_hit_reg;
    logic [bbrs_pkg::RSUM_W-1:0]   byp_store_data_reg;

    // stage 2: window sum, stage 3: scaled product
    logic                          s2_valid_reg;
    logic [bbrs_pkg::CSUM_W-1:0]   s2_csum_reg;
    logic [bbrs_pkg::COL_W-1:0]    s2_col_reg;
    logic [bbrs_pkg::ROW_W-1:0]    s2_row_reg;
    logic                          s2_last_reg;
    logic                          s3_valid_reg;
    logic [bbrs_pkg::PROD_W-1:0]   s3_prod_reg;
    logic [bbrs_pkg::COL_W-1:0]    s3_col_reg;
    logic [bbrs_pkg::ROW_W-1:0]    s3_row_reg;
    logic                          s3_last_reg;

    // results pending anywhere between acceptance and delivery
    logic [bbrs_pkg::OCC_W-1:0]    occ_reg;
    logic [bbrs_pkg::OCC_W-1:0]    occ_next;

    // combinational
    logic                          cfg_we;
    logic                          accept;
    logic [bbrs_pkg::HR_W-1:0]     hr_eff;
    logic [bbrs_pkg::VR_W-1:0]     vr_eff;
    logic [bbrs_pkg::HLEN_W-1:0]   hlen;
    logic [bbrs_pkg::VLEN_W-1:0]   vlen;
    logic [bbrs_pkg::AREA_W-1:0]   area;
    logic [bbrs_pkg::COL_W:0]      eff_width;
    logic [bbrs_pkg::ROW_W:0]      eff_height;
    logic [bbrs_pkg::COL_W-1:0]    last_col;
    logic [bbrs_pkg::ROW_W-1:0]    last_row;
    logic [bbrs_pkg::HSLOT_W-1:0]  hs;
    logic [bbrs_pkg::HSLOT_W-1:0]  hs_next;
    logic [bbrs_pkg::PIX_W-1:0]    old_pix;
    logic [bbrs_pkg::RSUM_W-1:0]   rsum_base;
    logic [bbrs_pkg::RSUM_W-1:0]   rsum_new;
    logic                          emit_h;
    logic                          emit;
    logic [bbrs_pkg::COL_W-1:0]    c_center;
    logic [bbrs_pkg::STORE_AW-1:0] store_addr;
    logic [bbrs_pkg::CSUM_W-1:0]   col_rdata;
    logic [bbrs_pkg::RSUM_W-1:0]   store_rdata;
    logic [bbrs_pkg::CSUM_W-1:0]   col_old;
    logic [bbrs_pkg::RSUM_W-1:0]   store_old;
    logic [bbrs_pkg::CSUM_W-1:0]   csum_new;
    logic                          out_pop;
    bbrs_pkg::div_status_t         div_status;
    bbrs_pkg::result_t             push_data;
    bbrs_pkg::result_t             head_data;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign in_ready  = !div_status.busy && !start_reg &&
                       (occ_reg < bbrs_pkg::OCC_W'(bbrs_pkg::OUT_DEPTH));
    assign accept    = in_valid && in_ready;

    // effective geometry, clamped to the supported range
    always_comb
    begin
        hr_eff = (32'(h_radius_reg) > bbrs_pkg::MAX_H_RADIUS)
               ? bbrs_pkg::HR_W'(bbrs_pkg::MAX_H_RADIUS) : bbrs_pkg::HR_W'(h_radius_reg);
        vr_eff = (32'(v_radius_reg) > bbrs_pkg::MAX_V_RADIUS)
               ? bbrs_pkg::VR_W'(bbrs_pkg::MAX_V_RADIUS) : bbrs_pkg::VR_W'(v_radius_reg);
        hlen   = bbrs_pkg::HLEN_W'({hr_eff, 1'b0}) + bbrs_pkg::HLEN_W'(1);
        vlen   = bbrs_pkg::VLEN_W'({vr_eff, 1'b0}) + bbrs_pkg::VLEN_W'(1);
        area   = bbrs_pkg::AREA_W'(32'(hlen) * 32'(vlen));

        if (line_width_reg == '0)
        begin
            eff_width = (bbrs_pkg::COL_W + 1)'(1);
        end
        else if (32'(line_width_reg) > bbrs_pkg::MAX_WIDTH)
        begin
            eff_width = (bbrs_pkg::COL_W + 1)'(bbrs_pkg::MAX_WIDTH);
        end
        else
        begin
            eff_width = (bbrs_pkg::COL_W + 1)'(line_width_reg);
        end

        if (frame_height_reg == '0)
        begin
            eff_height = (bbrs_pkg::ROW_W + 1)'(1);
        end
        else if (32'(frame_height_reg) > bbrs_pkg::MAX_HEIGHT)
        begin
            eff_height = (bbrs_pkg::ROW_W + 1)'(bbrs_pkg::MAX_HEIGHT);
        end
        else
        begin
            eff_height = (bbrs_pkg::ROW_W + 1)'(frame_height_reg);
        end

        last_col = bbrs_pkg::COL_W'(eff_width - (bbrs_pkg::COL_W + 1)'(1));
        last_row = bbrs_pkg::ROW_W'(eff_height - (bbrs_pkg::ROW_W + 1)'(1));
    end

    // horizontal running sum on the incoming pixel
    always_comb
    begin
        hs      = (col_reg == '0) ? '0 : hslot_reg;
        hs_next = (32'(hs) == 32'(hlen) - 32'd1) ? '0 : hs + bbrs_pkg::HSLOT_W'(1);
        old_pix = window_reg[hs];
        rsum_base = (col_reg == '0) ? '0 : row_sum_reg;
        rsum_new  = rsum_base
                  - ((32'(col_reg) >= 32'(hlen)) ? bbrs_pkg::RSUM_W'(old_pix) : '0)
                  + bbrs_pkg::RSUM_W'(pixel_in);
        // a full horizontal window ends here, centered hr columns back
        emit_h   = 32'(col_reg) >= 32'({hr_eff, 1'b0});
        emit     = emit_h && (32'(row_reg) >= 32'({vr_eff, 1'b0}));
        c_center = col_reg - bbrs_pkg::COL_W'(hr_eff);
        store_addr = bbrs_pkg::STORE_AW'({vslot_reg, c_center});
    end

    // vertical update: drop the row leaving the window, add the new one
    always_comb
    begin
        col_old   = byp_col_hit_reg ? byp_col_data_reg : col_rdata;
        store_old = byp_store_hit_reg ? byp_store_data_reg : store_rdata;
        csum_new  = (s1_row_zero_reg ? '0 : col_old)
                  - (s1_sub_reg ? bbrs_pkg::CSUM_W'(store_old) : '0)
                  + bbrs_pkg::CSUM_W'(s1_rsum_reg);
    end

    // configuration and position control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_radius_reg     <= bbrs_pkg::RADIUS_W'(1);
            v_radius_reg     <= bbrs_pkg::RADIUS_W'(1);
            line_width_reg   <= bbrs_pkg::LINE_WIDTH_W'(1024);
            frame_height_reg <= bbrs_pkg::FRAME_HEIGHT_W'(768);
            start_reg        <= 1'b1;
            col_reg          <= '0;
            row_reg          <= '0;
            hslot_reg        <= '0;
            vslot_reg        <= '0;
            row_sum_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            occ_reg          <= '0;
        end
        else
        begin
            // divider loads in the cycle after the write, from the updated registers
            start_reg <= cfg_we && (cfg_index <= bbrs_pkg::CFG_FRAME_HEIGHT);
            if (cfg_we)
            begin
                case (cfg_index)
                    bbrs_pkg::CFG_H_RADIUS:
                    begin
                        h_radius_reg <= cfg_data[bbrs_pkg::RADIUS_W-1:0];
                    end
                    bbrs_pkg::CFG_V_RADIUS:
                    begin
                        v_radius_reg <= cfg_data[bbrs_pkg::RADIUS_W-1:0];
                    end
                    bbrs_pkg::CFG_LINE_WIDTH:
                    begin
                        line_width_reg <= cfg_data[bbrs_pkg::LINE_WIDTH_W-1:0];
                    end
                    bbrs_pkg::CFG_FRAME_HEIGHT:
                    begin
                        frame_height_reg <= cfg_data[bbrs_pkg::FRAME_HEIGHT_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
                // any write to a defined register restarts the frame
                if (cfg_index <= bbrs_pkg::CFG_FRAME_HEIGHT)
                begin
                    col_reg   <= '0;
                    row_reg   <= '0;
                    vslot_reg <= '0;
                end
            end
            else if (accept)
            begin
                row_sum_reg <= rsum_new;
                hslot_reg   <= hs_next;
                if (col_reg == last_col)
                begin
                    col_reg <= '0;
                    if (row_reg == last_row)
                    begin
                        row_reg   <= '0;
                        vslot_reg <= '0;
                    end
                    else
                    begin
                        row_reg   <= row_reg + bbrs_pkg::ROW_W'(1);
                        vslot_reg <= (32'(vslot_reg) == 32'(vlen) - 32'd1)
                                   ? '0 : vslot_reg + bbrs_pkg::VSLOT_W'(1);
                    end
                end
                else
                begin
                    col_reg <= col_reg + bbrs_pkg::COL_W'(1);
                end
            end

            s1_valid_reg <= accept && emit_h;
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            s3_valid_reg <= s2_valid_reg;
            occ_reg      <= occ_next;
        end
    end

    assign out_pop  = out_valid && out_ready;
    assign occ_next = occ_reg + bbrs_pkg::OCC_W'(accept && emit) - bbrs_pkg::OCC_W'(out_pop);

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_reg[hs]  <= pixel_in;
            s1_col_reg      <= c_center;
            s1_addr_reg     <= store_addr;
            s1_rsum_reg     <= rsum_new;
            s1_row_zero_reg <= row_reg == '0;
            s1_sub_reg      <= 32'(row_reg) >= 32'(vlen);
            s1_emit_reg     <= emit;
            s1_row_reg      <= row_reg - bbrs_pkg::ROW_W'(vr_eff);
            s1_last_reg     <= (col_reg == last_col) && (row_reg == last_row);
        end

        // forward a write that lands on the entry being read this cycle
        byp_col_hit_reg    <= s1_valid_reg && (s1_col_reg == c_center);
        byp_col_data_reg   <= csum_new;
        byp_store_hit_reg  <= s1_valid_reg && (s1_addr_reg == store_addr);
        byp_store_data_reg <= s1_rsum_reg;

        s2_csum_reg <= csum_new;
        s2_col_reg  <= s1_col_reg;
        s2_row_reg  <= s1_row_reg;
        s2_last_reg <= s1_last_reg;

        s3_prod_reg <= bbrs_pkg::PROD_W'(s2_csum_reg) * bbrs_pkg::PROD_W'(div_status.quotient);
        s3_col_reg  <= s2_col_reg;
        s3_row_reg  <= s2_row_reg;
        s3_last_reg <= s2_last_reg;
    end

    // column sums, one entry per column
    bbrs_ram #(
        .WIDTH (bbrs_pkg::CSUM_W),
        .DEPTH (bbrs_pkg::MAX_WIDTH)
    ) u_col_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (csum_new),
        .re    (accept && emit_h),
        .raddr (c_center),
        .rdata (col_rdata)
    );

    // horizontal sums of the rows inside the vertical window
    bbrs_ram #(
        .WIDTH (bbrs_pkg::RSUM_W),
        .DEPTH (bbrs_pkg::STORE_DEPTH)
    ) u_store_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (s1_rsum_reg),
        .re    (accept && emit_h),
        .raddr (store_addr),
        .rdata (store_rdata)
    );

    bbrs_recip_div u_recip_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .divisor (area),
        .status  (div_status)
    );

    always_comb
    begin
        push_data.pixel  = s3_prod_reg[bbrs_pkg::RECIP_SHIFT +: bbrs_pkg::PIX_W];
        push_data.column = s3_col_reg;
        push_data.row    = s3_row_reg;
        push_data.last   = s3_last_reg;
    end

    bbrs_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s3_valid_reg),
        .push_data  (push_data),
        .pop        (out_pop),
        .head_valid (out_valid),
        .head_data  (head_data)
    );

    assign pixel_out  = head_data.pixel;
    assign out_column = head_data.column;
    assign out_row    = head_data.row;
    assign frame_last = head_data.last;

endmodule

FILE: rtl/core/bbrs_checker.sv
module bbrs_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [bbrs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [bbrs_pkg::PIX_W-1:0]        pixel_out,
    input logic [bbrs_pkg::COL_W-1:0]        out_column,
    input logic [bbrs_pkg::ROW_W-1:0]        out_row,
    input logic                             frame_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out) &&
            $stable(out_column) && $stable(out_row) && $stable(frame_last))
        else $error("stalled result changed");

    // a write to a defined register blocks pixels while the reciprocal is rebuilt
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index <= bbrs_pkg::CFG_FRAME_HEIGHT)
            |=> !in_ready ##1 !in_ready)
        else $error("pixel taken during reciprocal update");

    // a result out of an empty queue comes from an accepted pixel
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 4))
        else $error("result without matching transaction");

endmodule

bind box_blur_running_sum bbrs_checker u_checker (.*);

FILE: dv/tb_box_blur_running_sum.sv
module tb_box_blur_running_sum;

    timeunit 1ns;
    timeprecision 1ps;

    import bbrs_pkg::*;

    // run shape
    localparam int RESET_CYCLES       = 7;
    localparam int MAX_GAP            = 10;
    localparam int SETTLE_CYCLES      = 12;     // covers the pipeline depth, plus margin
    localparam int RANDOM_PIXELS      = 320;
    localparam int PHASE_PIXEL_CAP    = 150;
    localparam int CYCLE_LIMIT        = 500000;
    localparam int RESET_FRAME_HEIGHT = 768;

    // register indexes past the end of the map, written to check they do nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_UNUSED = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAST_UNUSED  = 3'd7;

    typedef enum int {WRITE_NONE, WRITE_SIZE, WRITE_ALL} write_mode_t;
    typedef enum int {PIX_MIXED, PIX_BRIGHT, PIX_PATTERN} pixel_mode_t;

    // box blur predictor plus the queue of blurred pixels still owed by the block
    class blur_scoreboard;
        int unsigned     hrad_reg, vrad_reg, width_reg, height_reg;
        bit [PIX_W-1:0]  hwin[H_DEPTH];
        int unsigned     row_total;
        bit [RSUM_W-1:0] row_store[STORE_DEPTH];
        int unsigned     col_total[MAX_WIDTH];
        int unsigned     col_pos, row_pos;
        longint unsigned recip;
        result_t         pending_blurs[$];
        int              errors, checked, frames_closed;

        function new();
            hrad_reg   = 1;
            vrad_reg   = 1;
            width_reg  = MAX_WIDTH;
            height_reg = RESET_FRAME_HEIGHT;
            foreach (hwin[i]) hwin[i] = '0;
            foreach (col_total[i]) col_total[i] = 0;
            row_total     = 0;
            errors        = 0;
            checked       = 0;
            frames_closed = 0;
            restart_frame();
        endfunction

        function int unsigned eff_hrad();
            return (hrad_reg > MAX_H_RADIUS) ? MAX_H_RADIUS : hrad_reg;
        endfunction

        function int unsigned eff_vrad();
            return (vrad_reg > MAX_V_RADIUS) ? MAX_V_RADIUS : vrad_reg;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0)
                return 1;
            return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg == 0)
                return 1;
            return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        endfunction

        // any write to a defined register rebuilds the reciprocal and starts a new frame
        function void restart_frame();
            recip   = RECIP_NUM / ((2 * eff_hrad() + 1) * (2 * eff_vrad() + 1));
            col_pos = 0;
            row_pos = 0;
        endfunction

        function void note_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_H_RADIUS:     hrad_reg   = data[RADIUS_W-1:0];
                CFG_V_RADIUS:     vrad_reg   = data[RADIUS_W-1:0];
                CFG_LINE_WIDTH:   width_reg  = data[LINE_WIDTH_W-1:0];
                CFG_FRAME_HEIGHT: height_reg = data[FRAME_HEIGHT_W-1:0];
                default:          return;
            endcase
            restart_frame();
        endfunction

        function void note_pixel(bit [PIX_W-1:0] pix);
            int unsigned     hr, vr, hlen, vlen, w, h;
            int unsigned     col, row, hslot, c, vslot, slot, center_row;
            longint unsigned prod;
            result_t         blur;
            hr   = eff_hrad();
            vr   = eff_vrad();
            hlen = 2 * hr + 1;
            vlen = 2 * vr + 1;
            w    = eff_width();
            h    = eff_height();
            if (col_pos >= w)
                col_pos = 0;
            if (row_pos >= h)
                row_pos = 0;
            col = col_pos;
            row = row_pos;

            if (col == 0 && row == 0)
                foreach (col_total[i]) col_total[i] = 0;
            if (col == 0)
                row_total = 0;

            // horizontal running sum over the last hlen pixels of the row
            hslot = col % hlen;
            if (col >= hlen)
                row_total -= hwin[hslot];
            hwin[hslot] = pix;
            row_total  += pix;

            if (col >= 2 * hr)
            begin
                // vertical sum of the last vlen row sums for the centered column
                c     = (col - hr) % MAX_WIDTH;
                vslot = row % vlen;
                slot  = vslot * MAX_WIDTH + c;
                if (row >= vlen)
                    col_total[c] -= row_store[slot];
                row_store[slot] = row_total[RSUM_W-1:0];
                col_total[c]   += row_total;

                if (row >= 2 * vr)
                begin
                    prod        = col_total[c];
                    prod        = (prod * recip) >> RECIP_SHIFT;
                    center_row  = row - vr;
                    blur.pixel  = prod[PIX_W-1:0];
                    blur.column = c[COL_W-1:0];
                    blur.row    = center_row[ROW_W-1:0];
                    blur.last   = (col == w - 1 && row == h - 1);
                    pending_blurs.push_back(blur);
                end
            end

            col_pos = col + 1;
            if (col_pos == w)
            begin
                col_pos = 0;
                row_pos = row + 1;
                if (row_pos == h)
                    row_pos = 0;
            end
        endfunction

        function void compare_field(string label, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_blurs.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual pixel %0d col %0d row %0d",
                         $time, got.pixel, got.column, got.row);
                return;
            end
            want = pending_blurs.pop_front();
            checked++;
            if (want.last)
                frames_closed++;
            compare_field("pixel_out",  want.pixel,  got.pixel);
            compare_field("out_column", want.column, got.column);
            compare_field("out_row",    want.row,    got.row);
            compare_field("frame_last", want.last,   got.last);
        endfunction
    endclass

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // every input starts at a known value
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic [PIX_W-1:0]       pixel_in  = '0;
    logic                   out_ready = 1'b0;

    logic             cfg_ready;
    logic             in_ready;
    logic             out_valid;
    logic [PIX_W-1:0] pixel_out;
    logic [COL_W-1:0] out_column;
    logic [ROW_W-1:0] out_row;
    logic             frame_last;

    blur_scoreboard sb;

    // per-phase idle style: burst means no gaps on that side
    bit in_burst  = 1'b0;
    bit out_burst = 1'b0;

    int pixels_sent  = 0;
    int config_count = 0;
    int hold_count   = 0;
    int cycle_count  = 0;

    always #1 clk = ~clk;

    box_blur_running_sum uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_in   (pixel_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out),
        .out_column (out_column),
        .out_row    (out_row),
        .frame_last (frame_last)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     sb.pending_blurs.size());
            $display("tb: failure");
            $finish;
        end
    end

    // wait until every owed result is out, then let the pipeline settle
    task automatic drain();
        while (sb.pending_blurs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one config transaction; valid is left high so back-to-back writes stay clean
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.note_config(idx, data);
        config_count++;
    endtask

    // one pixel transaction with a random lead-in gap
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        bit hold;
        gap  = in_burst ? 0 : $urandom_range(MAX_GAP);
        // now and then hold the stream until the output side has caught up
        hold = (sb.pending_blurs.size() != 0) && ($urandom_range(63) == 0);
        if (gap != 0 || hold)
            in_valid <= 1'b0;
        if (hold)
        begin
            hold_count++;
            while (sb.pending_blurs.size() != 0)
                @(posedge clk);
        end
        repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        pixel_in <= pix;
        do @(posedge clk); while (!in_ready);
        sb.note_pixel(pix);
        pixels_sent++;
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(pixel_mode_t pmode, int idx);
        case (pmode)
            PIX_PATTERN:
                case (idx % 8)
                    0:       return 8'h00;
                    1:       return 8'hFF;
                    2:       return 8'hAA;
                    3:       return 8'h55;
                    4:       return 8'h01;
                    5:       return 8'h80;
                    6:       return 8'hFE;
                    default: return 8'h7F;
                endcase
            // mostly saturated to push the column sums up
            PIX_BRIGHT:
                return ($urandom_range(3) != 0) ? PIX_MAX[PIX_W-1:0] : PIX_W'($urandom);
            default:
                case ($urandom_range(7))
                    0:       return '0;
                    1:       return PIX_MAX[PIX_W-1:0];
                    default: return PIX_W'($urandom);
                endcase
        endcase
    endfunction

    // one phase: settle, optionally reprogram, then stream pixels
    task automatic run_phase(input write_mode_t mode, input int hr, input int vr,
                             input int w, input int h, input int npix,
                             input pixel_mode_t pmode);
        logic [CFG_DATA_W-1:0] data;
        drain();
        in_burst  = ($urandom_range(3) == 0);
        out_burst = ($urandom_range(3) == 0);
        // writes to unmapped indexes should leave the frame position alone
        if ($urandom_range(2) == 0)
            write_reg(CFG_INDEX_W'($urandom_range(CFG_LAST_UNUSED, CFG_FIRST_UNUSED)),
                      CFG_DATA_W'($urandom));
        if (mode == WRITE_ALL)
        begin
            data = CFG_DATA_W'($urandom);
            data[RADIUS_W-1:0] = hr[RADIUS_W-1:0];
            write_reg(CFG_H_RADIUS, data);
            data = CFG_DATA_W'($urandom);
            data[RADIUS_W-1:0] = vr[RADIUS_W-1:0];
            write_reg(CFG_V_RADIUS, data);
        end
        if (mode != WRITE_NONE)
        begin
            data = CFG_DATA_W'($urandom);
            data[LINE_WIDTH_W-1:0] = w[LINE_WIDTH_W-1:0];
            write_reg(CFG_LINE_WIDTH, data);
            write_reg(CFG_FRAME_HEIGHT, h[FRAME_HEIGHT_W-1:0]);
        end
        cfg_valid <= 1'b0;
        for (int i = 0; i < npix; i++)
            send_pixel(pick_pixel(pmode, i));
        in_valid <= 1'b0;
    endtask

    // output side: random stall before each result, check on every transaction
    initial
    begin : result_sink
        int      stall;
        result_t got;
        @(posedge rst_n);
        forever
        begin
            stall = out_burst ? 0 : $urandom_range(MAX_GAP);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.pixel  = pixel_out;
            got.column = out_column;
            got.row    = out_row;
            got.last   = frame_last;
            sb.check_result(got);
        end
    end

    initial
    begin : stimulus
        int hr, vr, w, h, weff, heff, npix, base;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed: border pixels under the reset geometry give nothing
        run_phase(WRITE_NONE, 0, 0, 0, 0, 3, PIX_PATTERN);
        // small frame with the reset radii, so the reset reciprocal is used
        run_phase(WRITE_SIZE, 0, 0, 4, 3, 12, PIX_PATTERN);
        // zero radii: every pixel is its own window, frame wraps once
        run_phase(WRITE_ALL, 0, 0, 3, 2, 8, PIX_PATTERN);

        // extremes: widest horizontal window over a few rows with mostly saturated input
        run_phase(WRITE_ALL, MAX_H_RADIUS, 2, 33, 6, 198, PIX_BRIGHT);
        // widest horizontal window on a one-row frame
        run_phase(WRITE_ALL, MAX_H_RADIUS, 0, 40, 1, 45, PIX_MIXED);
        // tallest vertical window on a one-column frame
        run_phase(WRITE_ALL, 0, MAX_V_RADIUS, 1, 31, 40, PIX_MIXED);
        // widest line and tallest frame
        run_phase(WRITE_ALL, 0, 0, MAX_WIDTH, MAX_HEIGHT, 60, PIX_MIXED);
        // oversize width and height clamp to the maximum
        run_phase(WRITE_ALL, 0, 0, 2047, 8191, 40, PIX_MIXED);
        // zero width and height act as a 1x1 frame, every pixel closes it
        run_phase(WRITE_ALL, 0, 0, 0, 0, 20, PIX_MIXED);

        // random geometry, mostly small so frames close often
        base = pixels_sent;
        while (pixels_sent - base < RANDOM_PIXELS)
        begin
            if ($urandom_range(3) == 0)
            begin
                // keep going in the current frame
                run_phase(WRITE_NONE, 0, 0, 0, 0, $urandom_range(60, 1), PIX_MIXED);
            end
            else
            begin
                hr = ($urandom_range(7) == 0) ? $urandom_range(MAX_H_RADIUS) : $urandom_range(3);
                vr = ($urandom_range(7) == 0) ? $urandom_range(MAX_V_RADIUS) : $urandom_range(3);
                w  = 2 * hr + $urandom_range(8);
                h  = 2 * vr + $urandom_range(4);
                weff = (w == 0) ? 1 : w;
                heff = (h == 0) ? 1 : h;
                npix = weff * heff * ($urandom_range(1) + 1) + $urandom_range(weff);
                if (npix > PHASE_PIXEL_CAP)
                    npix = PHASE_PIXEL_CAP;
                run_phase(WRITE_ALL, hr, vr, w, h, npix, PIX_MIXED);
            end
        end

        // everything owed must arrive, and nothing more after it
        drain();

        $display("run covered %0d pixels over %0d register writes and %0d stream holds",
                 pixels_sent, config_count, hold_count);
        $display("%0d blurred pixels checked, %0d frame ends, radii 0 to 15, sizes 1 to max",
                 sb.checked, sb.frames_closed);
        if (sb.errors == 0 && sb.pending_blurs.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/bbrs_pkg.sv
rtl/core/bbrs_ram.sv
rtl/core/bbrs_recip_div.sv
rtl/core/bbrs_out_queue.sv
rtl/core/box_blur_running_sum.sv
rtl/core/bbrs_checker.sv
dv/tb_box_blur_running_sum.sv
